FILE: rtl/core/wpc_pkg.sv
// ----------------------------------------------------------------------------
// wpc_pkg: shared types and constants of the windowed point centroid filter
// Widths, the ring command group and the control state encoding.
// ----------------------------------------------------------------------------
package wpc_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int COORD_W    = 24;
  localparam int CNT_W      = 5;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int SUM_W      = COORD_W + SLOT_W + 1;
  localparam int STEP_W     = $clog2(SUM_W);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [CNT_W-1:0]          count_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [STEP_W-1:0]         step_t;

  localparam count_t WIN_RESET = count_t'(10);

  // Commands from the sequencer to the ring store.
  typedef struct packed {
    logic clear;   // drop all held points
    logic remove;  // take the oldest point out when full, write the new one
    logic insert;  // add the new point into the sums
  } ring_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_START,
    ST_DIV,
    ST_HOLD
  } state_t;

endpackage

FILE: rtl/core/wpc_in_if.sv
// ----------------------------------------------------------------------------
// wpc_in_if: input channel of the centroid filter
// Carries one point item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wpc_in_if;
  logic            valid;
  logic            ready;
  wpc_pkg::coord_t point_x;
  wpc_pkg::coord_t point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

FILE: rtl/core/wpc_out_if.sv
// ----------------------------------------------------------------------------
// wpc_out_if: result channel of the centroid filter
// Carries one mean item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface wpc_out_if;
  logic            valid;
  logic            ready;
  wpc_pkg::coord_t mean_x;
  wpc_pkg::coord_t mean_y;
  wpc_pkg::count_t points_held;

  modport source (output valid, output mean_x, output mean_y, output points_held,
                  input ready);
  modport sink   (input valid, input mean_x, input mean_y, input points_held,
                  output ready);
endinterface

FILE: rtl/core/wpc_ring.sv
// ----------------------------------------------------------------------------
// wpc_ring: point ring with running sums
// Holds the most recent points, the write slot, the fill count and the sums.
// ----------------------------------------------------------------------------
module wpc_ring (
  input  logic               clk,
  input  logic               rst_n,
  input  wpc_pkg::ring_cmd_t cmd,
  input  wpc_pkg::count_t    win,
  input  wpc_pkg::coord_t    point_x,
  input  wpc_pkg::coord_t    point_y,
  output wpc_pkg::sum_t      sum_x,
  output wpc_pkg::sum_t      sum_y,
  output wpc_pkg::count_t    fill
);

  // Entries are only read once the window has been filled since the last
  // clear, so the ring itself needs no reset.
  wpc_pkg::coord_t ring_x_r [wpc_pkg::MAX_WINDOW];
  wpc_pkg::coord_t ring_y_r [wpc_pkg::MAX_WINDOW];

  wpc_pkg::slot_t  slot_r, slot_nxt;
  wpc_pkg::count_t fill_r, fill_nxt;
  wpc_pkg::sum_t   sum_x_r, sum_x_nxt;
  wpc_pkg::sum_t   sum_y_r, sum_y_nxt;

  wpc_pkg::slot_t  slot_cur;
  wpc_pkg::count_t slot_inc;

  always_comb begin
    slot_cur  = (wpc_pkg::count_t'(slot_r) >= win) ? '0 : slot_r;
    slot_inc  = wpc_pkg::count_t'(slot_cur) + wpc_pkg::count_t'(1);
    slot_nxt  = slot_r;
    fill_nxt  = fill_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    if (cmd.clear) begin
      slot_nxt  = '0;
      fill_nxt  = '0;
      sum_x_nxt = '0;
      sum_y_nxt = '0;
    end else if (cmd.remove) begin
      if (fill_r >= win) begin
        sum_x_nxt = sum_x_r - wpc_pkg::sum_t'(ring_x_r[slot_cur]);
        sum_y_nxt = sum_y_r - wpc_pkg::sum_t'(ring_y_r[slot_cur]);
        fill_nxt  = win;
      end else begin
        fill_nxt  = fill_r + wpc_pkg::count_t'(1);
      end
      slot_nxt = (slot_inc >= win) ? '0 : slot_inc[wpc_pkg::SLOT_W-1:0];
    end else if (cmd.insert) begin
      sum_x_nxt = sum_x_r + wpc_pkg::sum_t'(point_x);
      sum_y_nxt = sum_y_r + wpc_pkg::sum_t'(point_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      fill_r  <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else begin
      slot_r  <= slot_nxt;
      fill_r  <= fill_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.remove && !cmd.clear) begin
      ring_x_r[slot_cur] <= point_x;
      ring_y_r[slot_cur] <= point_y;
    end
  end

  assign sum_x = sum_x_r;
  assign sum_y = sum_y_r;
  assign fill  = fill_r;

endmodule

FILE: rtl/core/wpc_sdiv.sv
// ----------------------------------------------------------------------------
// wpc_sdiv: bit-serial signed divider
// Divides a signed sum by a small unsigned count, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module wpc_sdiv (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  wpc_pkg::sum_t   dividend,
  input  wpc_pkg::count_t divisor,
  output logic            done,
  output wpc_pkg::coord_t quotient
);

  // The dividend magnitude shifts out at the top while quotient bits shift in
  // at the bottom, so after all steps the register holds the quotient.
  logic [wpc_pkg::SUM_W-1:0] mag_r, mag_nxt;
  wpc_pkg::count_t           rem_r, rem_nxt;
  wpc_pkg::count_t           div_r, div_nxt;
  logic                      neg_r, neg_nxt;
  wpc_pkg::step_t            step_r, step_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;

  logic [wpc_pkg::CNT_W:0]   trial;
  logic [wpc_pkg::CNT_W:0]   diff;
  logic                      q_bit;
  wpc_pkg::coord_t           q_mag;

  always_comb begin
    trial    = {rem_r, mag_r[wpc_pkg::SUM_W-1]};
    diff     = trial - {1'b0, div_r};
    q_bit    = (trial >= {1'b0, div_r});
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      mag_nxt  = dividend[wpc_pkg::SUM_W-1] ? -dividend : dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      neg_nxt  = dividend[wpc_pkg::SUM_W-1];
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      mag_nxt  = {mag_r[wpc_pkg::SUM_W-2:0], q_bit};
      rem_nxt  = q_bit ? diff[wpc_pkg::CNT_W-1:0] : trial[wpc_pkg::CNT_W-1:0];
      step_nxt = step_r + wpc_pkg::step_t'(1);
      if (step_r == wpc_pkg::step_t'(wpc_pkg::SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  assign q_mag    = mag_r[wpc_pkg::COORD_W-1:0];
  assign quotient = neg_r ? -q_mag : q_mag;
  assign done     = done_r;

endmodule

FILE: rtl/core/windowed_point_centroid_filter_top.sv
// ----------------------------------------------------------------------------
// windowed_point_centroid_filter_top: moving average of 2-D target points
// Averages the most recent points of a configurable window, x and y apart.
// ----------------------------------------------------------------------------
// Each input item is one point (x, y) in signed fixed point with 8 fraction
// bits. The block keeps the last window_size points in a ring together with
// running x and y sums, and for every point it returns one item with the mean
// of the points held, truncated toward zero, and the number of points that
// entered that mean. While the window fills, that number counts up from 1.
// A window size of zero acts as one, and sizes above 16 act as 16. Writing
// the window size register also empties the ring, so the next point starts
// a new window; write it only while the block is idle. From acceptance to
// the next acceptance, when the result side keeps up, an item passes these
// steps: ST_SUB and ST_ADD update the sums, ST_START launches the dividers,
// the two bit-serial dividers run in ST_DIV (one quotient bit per cycle
// across the 29-bit sum) until their done flags are seen, ST_HOLD hands the
// result to the output register and the block is back in ST_IDLE before
// the next point is taken. The output register lets the next item be
// accepted while a finished mean still waits to be taken; only when a
// second mean is ready before the first is taken does the block stall, for
// as long as the result side holds ready low.
// ----------------------------------------------------------------------------
module windowed_point_centroid_filter_top (
  input  logic            clk,
  input  logic            rst_n,
  wpc_in_if.sink          in_ch,
  wpc_out_if.source       out_ch,
  input  logic            cfg_wr_en,
  input  wpc_pkg::count_t cfg_wr_data
);

  wpc_pkg::state_t    state_r, state_nxt;
  wpc_pkg::count_t    window_r, window_nxt;
  wpc_pkg::count_t    win_eff;

  // The accepted point is held here while the ring and sums are updated.
  wpc_pkg::coord_t    px_r, px_nxt;
  wpc_pkg::coord_t    py_r, py_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  wpc_pkg::coord_t    mean_x_r, mean_x_nxt;
  wpc_pkg::coord_t    mean_y_r, mean_y_nxt;
  wpc_pkg::count_t    held_r, held_nxt;

  wpc_pkg::ring_cmd_t ring_cmd;
  wpc_pkg::sum_t      sum_x;
  wpc_pkg::sum_t      sum_y;
  wpc_pkg::count_t    fill;

  logic               div_start;
  logic               div_x_done;
  logic               div_y_done;
  wpc_pkg::coord_t    quot_x;
  wpc_pkg::coord_t    quot_y;

  logic               in_fire;

  // Clamp the register to the range the ring supports.
  always_comb begin
    if (window_r == '0) begin
      win_eff = wpc_pkg::count_t'(1);
    end else if (window_r > wpc_pkg::count_t'(wpc_pkg::MAX_WINDOW)) begin
      win_eff = wpc_pkg::count_t'(wpc_pkg::MAX_WINDOW);
    end else begin
      win_eff = window_r;
    end
  end

  assign in_ch.ready = (state_r == wpc_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    out_valid_nxt = out_valid_r;
    mean_x_nxt    = mean_x_r;
    mean_y_nxt    = mean_y_r;
    held_nxt      = held_r;
    ring_cmd      = '0;
    div_start     = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      window_nxt     = cfg_wr_data;
      ring_cmd.clear = 1'b1;
    end

    case (state_r)
      wpc_pkg::ST_IDLE: begin
        if (in_fire) begin
          px_nxt    = in_ch.point_x;
          py_nxt    = in_ch.point_y;
          state_nxt = wpc_pkg::ST_SUB;
        end
      end
      wpc_pkg::ST_SUB: begin
        // Drop the oldest point when the window is full and store the new one.
        ring_cmd.remove = 1'b1;
        state_nxt       = wpc_pkg::ST_ADD;
      end
      wpc_pkg::ST_ADD: begin
        ring_cmd.insert = 1'b1;
        state_nxt       = wpc_pkg::ST_START;
      end
      wpc_pkg::ST_START: begin
        div_start = 1'b1;
        state_nxt = wpc_pkg::ST_DIV;
      end
      wpc_pkg::ST_DIV: begin
        // Both dividers run in lockstep and finish in the same cycle.
        if (div_x_done && div_y_done) begin
          state_nxt = wpc_pkg::ST_HOLD;
        end
      end
      wpc_pkg::ST_HOLD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          mean_x_nxt    = quot_x;
          mean_y_nxt    = quot_y;
          held_nxt      = fill;
          state_nxt     = wpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wpc_pkg::ST_IDLE;
      window_r    <= wpc_pkg::WIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    mean_x_r <= mean_x_nxt;
    mean_y_r <= mean_y_nxt;
    held_r   <= held_nxt;
  end

  wpc_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ring_cmd),
    .win     (win_eff),
    .point_x (px_r),
    .point_y (py_r),
    .sum_x   (sum_x),
    .sum_y   (sum_y),
    .fill    (fill)
  );

  wpc_sdiv u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_x),
    .divisor  (fill),
    .done     (div_x_done),
    .quotient (quot_x)
  );

  wpc_sdiv u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_y),
    .divisor  (fill),
    .done     (div_y_done),
    .quotient (quot_y)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mean_x      = mean_x_r;
  assign out_ch.mean_y      = mean_y_r;
  assign out_ch.points_held = held_r;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the windowed point centroid filter
// Sends point items to the block and keeps its own model of the point ring
// and the running sums. Every mean item that comes back is compared field by
// field with the oldest predicted mean, across several window sizes.
// ----------------------------------------------------------------------------
module testbench;

  // The mean that one point item should produce and the points held for it.
  typedef struct {
    wpc_pkg::coord_t mean_x;
    wpc_pkg::coord_t mean_y;
    wpc_pkg::count_t points_held;
  } mean_item_t;

  localparam wpc_pkg::coord_t COORD_MAX = wpc_pkg::coord_t'(24'h7FFFFF);
  localparam wpc_pkg::coord_t COORD_MIN = wpc_pkg::coord_t'(24'h800000);
  // After the last mean item, a quiet stretch longer than one item takes
  // means no point is still being worked on.
  localparam int     SETTLE_CYCLES = 40;
  // The slowest correct run sends about 1250 items, with stalls on both
  // sides. The limit leaves a wide margin over its length.
  localparam int     CYCLE_LIMIT   = 600000;
  localparam int     IDLE_PERCENT  = 7;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_wr_en;
  wpc_pkg::count_t cfg_wr_data;

  wpc_in_if  in_ch ();
  wpc_out_if out_ch ();

  windowed_point_centroid_filter_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Model of the block: the point ring, the running sums and the window size.
  wpc_pkg::coord_t ring_hist_x [wpc_pkg::MAX_WINDOW];
  wpc_pkg::coord_t ring_hist_y [wpc_pkg::MAX_WINDOW];
  longint          run_sum_x;
  longint          run_sum_y;
  int              next_slot;
  int              points_in_window;
  wpc_pkg::count_t window_reg;

  mean_item_t pending_means[$];
  mean_item_t head_mean;
  int         error_count = 0;
  int         cycle_count = 0;
  // When set, neither side idles: the block runs at its full rate.
  bit         steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit: a hang anywhere in the block ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The result side stalls at random, except during the steady stretch.
  always @(negedge clk) begin
    out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Every mean item taken from the block must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_means.size() == 0) begin
        $error("mean item with no point waiting for it: x %0d, y %0d, held %0d",
               out_ch.mean_x, out_ch.mean_y, out_ch.points_held);
        error_count++;
      end else begin
        head_mean = pending_means.pop_front();
        if (out_ch.mean_x !== head_mean.mean_x) begin
          $error("mean_x mismatch: expected %0d, got %0d", head_mean.mean_x, out_ch.mean_x);
          error_count++;
        end
        if (out_ch.mean_y !== head_mean.mean_y) begin
          $error("mean_y mismatch: expected %0d, got %0d", head_mean.mean_y, out_ch.mean_y);
          error_count++;
        end
        if (out_ch.points_held !== head_mean.points_held) begin
          $error("points_held mismatch: expected %0d, got %0d",
                 head_mean.points_held, out_ch.points_held);
          error_count++;
        end
      end
    end
  end

  // Empties the modeled ring, as reset and every window size write do.
  function automatic void clear_window();
    for (int i = 0; i < wpc_pkg::MAX_WINDOW; i++) begin
      ring_hist_x[i] = '0;
      ring_hist_y[i] = '0;
    end
    run_sum_x        = 0;
    run_sum_y        = 0;
    next_slot        = 0;
    points_in_window = 0;
  endfunction

  // Adds one point to the modeled window and queues the mean it produces.
  // A window size of zero acts as one, and sizes above the ring act as the
  // full ring. Once the window is full the oldest point leaves the sums.
  function automatic void predict_mean(wpc_pkg::coord_t px, wpc_pkg::coord_t py);
    int         span;
    int         slot;
    mean_item_t mean;
    span = int'(window_reg);
    if (span < 1) span = 1;
    if (span > wpc_pkg::MAX_WINDOW) span = wpc_pkg::MAX_WINDOW;
    slot = next_slot;
    if (slot >= span) slot = 0;
    if (points_in_window >= span) begin
      run_sum_x       -= ring_hist_x[slot];
      run_sum_y       -= ring_hist_y[slot];
      points_in_window = span;
    end else begin
      points_in_window++;
    end
    ring_hist_x[slot] = px;
    ring_hist_y[slot] = py;
    run_sum_x        += px;
    run_sum_y        += py;
    slot++;
    if (slot >= span) slot = 0;
    next_slot = slot;
    // Signed division of integers truncates toward zero, as the block does.
    mean.mean_x      = wpc_pkg::coord_t'(run_sum_x / longint'(points_in_window));
    mean.mean_y      = wpc_pkg::coord_t'(run_sum_y / longint'(points_in_window));
    mean.points_held = wpc_pkg::count_t'(points_in_window);
    pending_means.push_back(mean);
  endfunction

  // Offers one point item and returns at the falling edge after it was taken.
  // Valid stays high on return so that back-to-back items need no gap.
  task automatic send_point(wpc_pkg::coord_t px, wpc_pkg::coord_t py);
    if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < IDLE_PERCENT);
    end
    in_ch.valid   <= 1'b1;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    do @(posedge clk); while (!in_ch.ready);
    predict_mean(px, py);
    @(negedge clk);
  endtask

  // Holds the input back until every predicted mean has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_means.size() != 0);
  endtask

  // Writes the window size once the block is idle; this also empties the ring.
  task automatic set_window(wpc_pkg::count_t size);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    window_reg  = size;
    clear_window();
  endtask

  // Random coordinate, weighted toward the extremes, values near zero (where
  // truncation toward zero matters most) and large values of one sign.
  function automatic wpc_pkg::coord_t pick_coord();
    case ($urandom_range(9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3:    return wpc_pkg::coord_t'(int'($urandom_range(600)) - 300);
      4:       return wpc_pkg::coord_t'(int'($urandom_range(2)) - 1);
      5:       return wpc_pkg::coord_t'($urandom_range(8388607, 7000000));
      6:       return wpc_pkg::coord_t'(-int'($urandom_range(8388608, 7000000)));
      default: return wpc_pkg::coord_t'($urandom());
    endcase
  endfunction

  // The reset window of ten points: extremes, signs that cancel, sums that
  // do not divide evenly, and more points than the window so the ring wraps.
  task automatic test_reset_window();
    send_point(COORD_MAX, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN);
    send_point(COORD_MIN, COORD_MAX);
    send_point(-24'sd1, 24'sd1);
    send_point(24'sd0, 24'sd0);
    send_point(-24'sd3, 24'sd3);
    send_point(-24'sd1, 24'sd2);
    send_point(24'sd5, -24'sd7);
    send_point(24'sd1, -24'sd1);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN);
    send_point(-24'sd2, -24'sd5);
  endtask

  // A size of zero must act as one; a size of 31 must act as the full ring.
  task automatic test_window_limits();
    set_window(wpc_pkg::count_t'(0));
    send_point(COORD_MIN, 24'sd7);
    send_point(-24'sd7, COORD_MAX);
    send_point(24'sd3, -24'sd3);
    set_window(wpc_pkg::count_t'(31));
    send_point(COORD_MAX, -24'sd1);
    send_point(-24'sd1, COORD_MIN);
    send_point(COORD_MIN, 24'sd0);
    send_point(24'sd2, 24'sd1);
  endtask

  // Random points over a range of window sizes, with an occasional pause
  // until the block has handed out everything.
  task automatic test_random_windows();
    wpc_pkg::count_t sizes [8];
    sizes = '{wpc_pkg::count_t'(16), wpc_pkg::count_t'(17),
              wpc_pkg::count_t'(1), wpc_pkg::count_t'(2),
              wpc_pkg::count_t'(31), wpc_pkg::count_t'(0),
              wpc_pkg::count_t'(3), wpc_pkg::count_t'($urandom_range(31))};
    foreach (sizes[i]) begin
      set_window(sizes[i]);
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(99) == 0) wait_drained();
        send_point(pick_coord(), pick_coord());
      end
    end
  endtask

  // A long stretch at the full rate: no idling on either side.
  task automatic test_steady_stream();
    set_window(wpc_pkg::count_t'(16));
    steady = 1'b1;
    for (int n = 0; n < 200; n++) send_point(pick_coord(), pick_coord());
    steady = 1'b0;
  endtask

  // The sender stops until every mean is out, then carries on in the same
  // window, so the ring must keep its contents across the pause.
  task automatic test_drain_pauses();
    set_window(wpc_pkg::count_t'(5));
    for (int n = 0; n < 30; n++) begin
      if (n % 10 == 9) wait_drained();
      send_point(pick_coord(), pick_coord());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    out_ch.ready  = 1'b0;
    window_reg    = wpc_pkg::WIN_RESET;
    clear_window();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_window();
    test_window_limits();
    test_random_windows();
    test_steady_stream();
    test_drain_pauses();

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && pending_means.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
